>>> rtl/cfa_pkg.sv
// Shared types, codes and defaults of the clock frame allocator.
package cfa_pkg;

    localparam int FRAMES_DEF    = 64;
    localparam int PAGE_BITS_DEF = 20;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_TOUCH  = 2'd1,
        FUNC_UNLOCK = 2'd2,
        FUNC_FREE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_EMPTY = 2'd0,
        STAT_EVICT = 2'd1,
        STAT_NONE  = 2'd2
    } status_t;

    // Per-frame flag word kept in the flag RAM.
    typedef struct packed {
        logic occupied;
        logic locked;
        logic referenced;
    } flags_t;

    // Verdict of the frame evaluator on one frame.
    typedef struct packed {
        logic grant;
        logic second_chance;
        logic last;
    } dec_t;

endpackage

>>> rtl/cfa_ram.sv
// Single-port-write, single-port-read RAM with registered read and write bypass.
module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] mem_q_reg;
    logic [WIDTH-1:0] byp_data_reg;
    logic             byp_hit_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        mem_q_reg    <= mem[raddr];
        byp_hit_reg  <= we && (waddr == raddr);
        byp_data_reg <= wdata;
    end

    // A read that collides with a write returns the new data.
    assign rdata = byp_hit_reg ? byp_data_reg : mem_q_reg;

endmodule

>>> rtl/cfa_frame_eval.sv
// Frame evaluator: judges one frame's flags for the free scan or the clock sweep.
module cfa_frame_eval #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 8
) (
    input  logic              sweep_mode,
    input  cfa_pkg::flags_t   flags,
    input  logic [IDX_W-1:0]  ev_idx,
    input  logic [IDX_W-1:0]  last_idx,
    input  logic [CNT_W-1:0]  ev_cnt,
    input  logic [CNT_W-1:0]  sweep_last,
    output cfa_pkg::dec_t     dec
);

    logic usable;

    assign usable = !flags.locked && flags.occupied;

    always_comb begin
        if (sweep_mode) begin
            dec.grant         = usable && !flags.referenced;
            dec.second_chance = usable && flags.referenced;
            dec.last          = (ev_cnt == sweep_last);
        end else begin
            dec.grant         = !flags.locked && !flags.occupied;
            dec.second_chance = 1'b0;
            dec.last          = (ev_idx == last_idx);
        end
    end

endmodule

>>> rtl/clock_frame_allocator_unit.sv
// Top level of the clock (second chance) physical frame allocator.
//
// The block manages a table of FRAMES physical frames; the lowest frames_in_use of
// them (written through cfg_wr_en / cfg_wr_data, 0 acts as 1, values above FRAMES act
// as FRAMES) take part. A transaction on the s_ channel carries an operation in s_tuser:
// allocate, touch (mark referenced), unlock, or free. Only allocate returns a
// transaction on the m_ channel: status, granted frame, and the page evicted for
// write-back. Allocate first grants the lowest empty, unlocked frame; failing that the
// clock hand sweeps at most two turns, skipping locked and empty frames, clearing set
// referenced bits, and evicting the first unlocked, unreferenced occupied frame. A
// granted frame is left locked. All frame state sits in two RAMs with one read and one
// write port, walked one frame per cycle by a small sequencer around one shared frame
// evaluator, so the block takes one transaction at a time. Touch, unlock and free pass
// through a single operation state. An allocate scans the managed frames for an empty
// one; failing that it falls through to the sweep, in which the hand visits at most 2n
// frames, n being the managed frame count. An allocate also waits in its result state
// while the previous result still sits unaccepted on the m_ channel. After reset a
// clearing pass over all FRAMES frames zeroes the flag RAM; s_tready stays low during
// it, while configuration writes are taken at any time.
module clock_frame_allocator_unit #(
    parameter int FRAMES    = cfa_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = cfa_pkg::PAGE_BITS_DEF,
    localparam int IDX_W      = $clog2(FRAMES),
    localparam int CFG_W      = $clog2(FRAMES + 1),
    localparam int IN_TDATA_W = ((IDX_W + PAGE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((IDX_W + PAGE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration: frames_in_use
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // frame_index, page_id, zero pad
    input  logic [1:0]             s_tuser,   // func
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // granted_frame, evicted_page, zero pad
    output logic [2:0]             m_tuser    // status, evicted_valid
);

    localparam int CNT_W = $clog2(FRAMES) + 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OP,
        ST_SCAN,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        cfg_reg;
    cfa_pkg::func_t          func_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [PAGE_BITS-1:0]    page_reg;
    logic [IDX_W-1:0]        ptr_reg;
    logic [IDX_W-1:0]        hand_reg;
    logic [IDX_W-1:0]        clr_idx_reg;
    logic                    ev_valid_reg;
    logic [IDX_W-1:0]        ev_idx_reg;
    logic [CNT_W-1:0]        iss_cnt_reg;
    logic [CNT_W-1:0]        ev_cnt_reg;
    cfa_pkg::status_t        res_status_reg;
    logic [IDX_W-1:0]        res_frame_reg;
    logic [PAGE_BITS-1:0]    res_page_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic [2:0]              m_tuser_reg;

    // unpacked request fields
    logic [IDX_W-1:0]        s_frame_index;
    logic [PAGE_BITS-1:0]    s_page_id;
    cfa_pkg::func_t          s_func;
    logic                    s_accept;

    // managed frame count and derived limits
    logic [CFG_W-1:0]        n_mgd;
    logic [IDX_W-1:0]        last_idx;
    logic [CNT_W-1:0]        n_cnt;
    logic [CNT_W-1:0]        n2_cnt;
    logic [CNT_W-1:0]        sweep_last;
    logic [IDX_W-1:0]        hand_start;
    logic [IDX_W-1:0]        ptr_next;
    logic [IDX_W-1:0]        ev_next;
    logic                    idx_in_range;

    // RAM ports
    logic                    issue;
    logic [IDX_W-1:0]        rd_addr;
    logic                    flag_we;
    logic [IDX_W-1:0]        flag_waddr;
    cfa_pkg::flags_t         flag_wdata;
    cfa_pkg::flags_t         flag_rdata;
    logic                    own_we;
    logic [PAGE_BITS-1:0]    own_rdata;

    cfa_pkg::dec_t           dec;
    cfa_pkg::flags_t         granted_flags;

    assign s_frame_index = s_tdata[IDX_W-1:0];
    assign s_page_id     = s_tdata[IDX_W +: PAGE_BITS];
    assign s_func        = cfa_pkg::func_t'(s_tuser);
    assign s_tready      = (state_reg == ST_IDLE);
    assign s_accept      = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Clamp the register: 0 acts as 1, above FRAMES acts as FRAMES.
    always_comb begin
        if (cfg_reg == '0) begin
            n_mgd = CFG_W'(1);
        end else if (cfg_reg > CFG_W'(FRAMES)) begin
            n_mgd = CFG_W'(FRAMES);
        end else begin
            n_mgd = cfg_reg;
        end
    end

    assign last_idx     = IDX_W'(n_mgd - CFG_W'(1));
    assign n_cnt        = CNT_W'(n_mgd);
    assign n2_cnt       = n_cnt << 1;
    assign sweep_last   = n2_cnt - CNT_W'(1);
    assign hand_start   = (CFG_W'(hand_reg) >= n_mgd) ? '0 : hand_reg;
    assign ptr_next     = (ptr_reg == last_idx) ? '0 : ptr_reg + IDX_W'(1);
    assign ev_next      = (ev_idx_reg == last_idx) ? '0 : ev_idx_reg + IDX_W'(1);
    assign idx_in_range = (CFG_W'(idx_reg) < n_mgd);

    assign granted_flags = '{occupied: 1'b1, locked: 1'b1, referenced: 1'b0};

    cfa_frame_eval #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_eval (
        .sweep_mode (state_reg == ST_SWEEP),
        .flags      (flag_rdata),
        .ev_idx     (ev_idx_reg),
        .last_idx   (last_idx),
        .ev_cnt     (ev_cnt_reg),
        .sweep_last (sweep_last),
        .dec        (dec)
    );

    // Drive the RAM ports for the current step.
    always_comb begin
        issue      = 1'b0;
        rd_addr    = ptr_reg;
        flag_we    = 1'b0;
        flag_waddr = ev_idx_reg;
        flag_wdata = granted_flags;
        own_we     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                flag_we    = 1'b1;
                flag_waddr = clr_idx_reg;
                flag_wdata = '0;
            end
            ST_IDLE: begin
                // fetch the target frame while the request is taken
                rd_addr = s_frame_index;
            end
            ST_OP: begin
                flag_waddr = idx_reg;
                flag_wdata = flag_rdata;
                flag_we    = idx_in_range;
                case (func_reg)
                    cfa_pkg::FUNC_TOUCH: begin
                        flag_wdata.referenced = flag_rdata.referenced
                                                || flag_rdata.occupied;
                    end
                    cfa_pkg::FUNC_UNLOCK: begin
                        flag_wdata.locked = 1'b0;
                    end
                    cfa_pkg::FUNC_FREE: begin
                        flag_wdata = '0;
                    end
                    default: begin
                        flag_we = 1'b0;
                    end
                endcase
            end
            ST_SCAN: begin
                issue = (iss_cnt_reg < n_cnt);
                if (ev_valid_reg && dec.grant) begin
                    flag_we = 1'b1;
                    own_we  = 1'b1;
                end
            end
            ST_SWEEP: begin
                issue = (iss_cnt_reg < n2_cnt);
                if (ev_valid_reg && dec.grant) begin
                    flag_we = 1'b1;
                    own_we  = 1'b1;
                end else if (ev_valid_reg && dec.second_chance) begin
                    // second chance: drop the referenced bit, keep the rest
                    flag_we    = 1'b1;
                    flag_wdata = flag_rdata;
                    flag_wdata.referenced = 1'b0;
                end
            end
            ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    cfa_ram #(
        .WIDTH ($bits(cfa_pkg::flags_t)),
        .DEPTH (FRAMES)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (rd_addr),
        .rdata (flag_rdata)
    );

    cfa_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_owner_ram (
        .aclk  (aclk),
        .we    (own_we),
        .waddr (ev_idx_reg),
        .wdata (page_reg),
        .raddr (rd_addr),
        .rdata (own_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cfg_reg      <= CFG_W'(FRAMES);
            hand_reg     <= '0;
            clr_idx_reg  <= '0;
            ev_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                    if (clr_idx_reg == IDX_W'(FRAMES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        func_reg     <= s_func;
                        idx_reg      <= s_frame_index;
                        page_reg     <= s_page_id;
                        ptr_reg      <= '0;
                        iss_cnt_reg  <= '0;
                        ev_valid_reg <= 1'b0;
                        state_reg    <= (s_func == cfa_pkg::FUNC_ALLOC) ? ST_SCAN : ST_OP;
                    end
                end
                ST_OP: begin
                    state_reg <= ST_IDLE;
                end
                ST_SCAN: begin
                    // advance the read stream; evaluate the frame read last cycle
                    if (issue) begin
                        ptr_reg     <= ptr_next;
                        iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
                    end
                    ev_valid_reg <= issue;
                    ev_idx_reg   <= ptr_reg;
                    if (ev_valid_reg && dec.grant) begin
                        res_status_reg <= cfa_pkg::STAT_EMPTY;
                        res_frame_reg  <= ev_idx_reg;
                        res_page_reg   <= '0;
                        state_reg      <= ST_RESULT;
                    end else if (ev_valid_reg && dec.last) begin
                        // no empty frame: start the clock sweep
                        ptr_reg      <= hand_start;
                        hand_reg     <= hand_start;
                        iss_cnt_reg  <= '0;
                        ev_cnt_reg   <= '0;
                        ev_valid_reg <= 1'b0;
                        state_reg    <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (issue) begin
                        ptr_reg     <= ptr_next;
                        iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
                    end
                    ev_valid_reg <= issue;
                    ev_idx_reg   <= ptr_reg;
                    if (ev_valid_reg) begin
                        ev_cnt_reg <= ev_cnt_reg + CNT_W'(1);
                        if (dec.grant) begin
                            res_status_reg <= cfa_pkg::STAT_EVICT;
                            res_frame_reg  <= ev_idx_reg;
                            res_page_reg   <= own_rdata;
                            hand_reg       <= ev_next;
                            state_reg      <= ST_RESULT;
                        end else if (dec.last) begin
                            // two turns without a victim: hand stays at its start
                            res_status_reg <= cfa_pkg::STAT_NONE;
                            res_frame_reg  <= '0;
                            res_page_reg   <= '0;
                            state_reg      <= ST_RESULT;
                        end
                    end
                end
                ST_RESULT: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_TDATA_W'({res_page_reg, res_frame_reg});
                        m_tuser_reg  <= {res_status_reg == cfa_pkg::STAT_EVICT,
                                         res_status_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> test/cfa_checker.sv
// Frame allocator checker: watches both channels, predicts each grant and compares it.
`timescale 1ns / 1ps

module cfa_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          outstanding,
    output int          empty_grants,
    output int          evict_grants,
    output int          refusals
);

    localparam int NFRAMES = 64;

    typedef struct {
        cfa_pkg::status_t status;
        logic [5:0]       frame;
        logic [19:0]      page;
        logic             valid;
    } grant_t;

    logic [19:0] owner      [NFRAMES];
    bit          occupied   [NFRAMES];
    bit          locked     [NFRAMES];
    bit          referenced [NFRAMES];
    int unsigned hand;
    logic [6:0]  frames_cfg;

    grant_t pending_grants[$];

    function automatic int unsigned managed();
        int unsigned n;
        n = frames_cfg;
        if (n < 1) n = 1;
        if (n > NFRAMES) n = NFRAMES;
        return n;
    endfunction

    task automatic claim_frame(input int unsigned f, input logic [19:0] page);
        owner[f]      = page;
        occupied[f]   = 1'b1;
        locked[f]     = 1'b1;
        referenced[f] = 1'b0;
    endtask

    // Lowest empty unlocked frame first, then up to two turns of the clock hand.
    task automatic allocate_frame(input logic [19:0] page, output grant_t g);
        int unsigned n;
        int unsigned i;
        int unsigned f;
        bit          done;
        n        = managed();
        g.status = cfa_pkg::STAT_NONE;
        g.frame  = '0;
        g.page   = '0;
        g.valid  = 1'b0;
        done     = 1'b0;
        for (i = 0; i < n && !done; i++) begin
            if (!locked[i] && !occupied[i]) begin
                g.status = cfa_pkg::STAT_EMPTY;
                g.frame  = 6'(i);
                claim_frame(i, page);
                done = 1'b1;
            end
        end
        if (!done) begin
            if (hand >= n) hand = 0;
            for (i = 0; i < 2 * n && !done; i++) begin
                f    = hand;
                hand = (hand + 1 >= n) ? 0 : hand + 1;
                if (locked[f] || !occupied[f]) continue;
                if (referenced[f]) begin
                    referenced[f] = 1'b0;
                    continue;
                end
                g.status = cfa_pkg::STAT_EVICT;
                g.frame  = 6'(f);
                g.page   = owner[f];
                g.valid  = 1'b1;
                claim_frame(f, page);
                done = 1'b1;
            end
        end
    endtask

    task automatic report_field(input string name, input logic [19:0] exp_v,
                                input logic [19:0] got_v);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        grant_t           got;
        grant_t           want;
        grant_t           g;
        cfa_pkg::func_t   op;
        logic [5:0]       idx;
        logic [19:0]      page;
        if (!aresetn) begin
            for (int i = 0; i < NFRAMES; i++) begin
                owner[i]      = '0;
                occupied[i]   = 1'b0;
                locked[i]     = 1'b0;
                referenced[i] = 1'b0;
            end
            hand         = 0;
            frames_cfg   = 7'd64;
            pending_grants.delete();
            fail_count   = 0;
            empty_grants = 0;
            evict_grants = 0;
            refusals     = 0;
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) frames_cfg = cfg_wr_data;

            // compare results before adding the request of this edge
            if (m_tvalid && m_tready) begin
                got.status = cfa_pkg::status_t'(m_tuser[1:0]);
                got.valid  = m_tuser[2];
                got.frame  = m_tdata[5:0];
                got.page   = m_tdata[25:6];
                if (pending_grants.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d frame %0d",
                             $time, got.status, got.frame);
                    fail_count++;
                end else begin
                    want = pending_grants.pop_front();
                    if (got.status !== want.status)
                        report_field("status", 20'(want.status), 20'(got.status));
                    if (got.frame !== want.frame)
                        report_field("granted_frame", 20'(want.frame), 20'(got.frame));
                    if (got.page !== want.page)
                        report_field("evicted_page", want.page, got.page);
                    if (got.valid !== want.valid)
                        report_field("evicted_valid", 20'(want.valid), 20'(got.valid));
                end
            end

            if (s_tvalid && s_tready) begin
                op   = cfa_pkg::func_t'(s_tuser);
                idx  = s_tdata[5:0];
                page = s_tdata[25:6];
                if (op == cfa_pkg::FUNC_ALLOC) begin
                    allocate_frame(page, g);
                    pending_grants.push_back(g);
                    case (g.status)
                        cfa_pkg::STAT_EMPTY: empty_grants++;
                        cfa_pkg::STAT_EVICT: evict_grants++;
                        default:             refusals++;
                    endcase
                end else if (idx < managed()) begin
                    case (op)
                        cfa_pkg::FUNC_TOUCH: begin
                            if (occupied[idx]) referenced[idx] = 1'b1;
                        end
                        cfa_pkg::FUNC_UNLOCK: begin
                            locked[idx] = 1'b0;
                        end
                        default: begin
                            occupied[idx]   = 1'b0;
                            locked[idx]     = 1'b0;
                            referenced[idx] = 1'b0;
                        end
                    endcase
                end
            end
            outstanding <= pending_grants.size();
        end
    end

endmodule

>>> test/tb.sv
// Testbench top: drives requests and frame-count writes into the allocator, gives the verdict.
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 63;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;   // frame_index, page_id, zero pad
    logic [1:0]  s_tuser     = '0;   // func
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;            // granted_frame, evicted_page, zero pad
    logic [2:0]  m_tuser;            // status, evicted_valid

    int fail_count;
    int outstanding;
    int empty_grants;
    int evict_grants;
    int refusals;

    bit          steady = 1'b0;   // phase with no idling on either side
    logic [6:0]  frames_now = 7'd64;
    int          idle_cycles = 0;
    int          stall_left = 0;

    clock_frame_allocator_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    cfa_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .empty_grants (empty_grants),
        .evict_grants (evict_grants),
        .refusals     (refusals)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Result side: mostly ready, short stalls, now and then a long one.
    always @(posedge aclk) begin : ready_gen
        int r;
        if (!aresetn) begin
            stall_left = 0;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready <= 1'b1;
            end else if (r < 95) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                stall_left = $urandom_range(9, 39);
                m_tready <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no transaction and no write happen for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Present one request, after a random gap, and hold it until it is taken.
    task automatic send_req(input cfa_pkg::func_t op, input logic [5:0] idx,
                            input logic [19:0] page);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (steady || r < 60) gap = 0;
        else if (r < 90)      gap = $urandom_range(1, 3);
        else                  gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, page, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the request side idle until the block is back in idle with no result pending.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 || !s_tready) @(posedge aclk);
    endtask

    // Write the frame count only once the block has drained.
    task automatic set_frames(input logic [6:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        frames_now = value;
    endtask

    task automatic send_random();
        cfa_pkg::func_t op;
        int             r;
        int             n;
        logic [5:0]     idx;
        r = $urandom_range(0, 99);
        if (r < 35)      op = cfa_pkg::FUNC_ALLOC;
        else if (r < 60) op = cfa_pkg::FUNC_TOUCH;
        else if (r < 85) op = cfa_pkg::FUNC_UNLOCK;
        else             op = cfa_pkg::FUNC_FREE;
        n = (frames_now == 0) ? 1 : ((frames_now > 64) ? 64 : frames_now);
        // mostly target managed frames, sometimes anywhere
        if ($urandom_range(0, 99) < 85) idx = 6'($urandom_range(0, n - 1));
        else                            idx = 6'($urandom_range(0, 63));
        send_req(op, idx, 20'($urandom));
    endtask

    int frame_plan [10] = '{1, 64, 3, 127, 0, 8, 65, 16, 5, 2};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset frame count: extreme page into frame 0, touch an empty top frame
        send_req(cfa_pkg::FUNC_ALLOC, 6'd0, 20'hFFFFF);
        send_req(cfa_pkg::FUNC_TOUCH, 6'd63, 20'h00000);

        // four frames: fill, refuse, then second chance and eviction
        set_frames(7'd4);
        send_req(cfa_pkg::FUNC_ALLOC, 6'd0, 20'h00000);
        send_req(cfa_pkg::FUNC_ALLOC, 6'd0, 20'hAAAAA);
        send_req(cfa_pkg::FUNC_ALLOC, 6'd0, 20'h55555);
        send_req(cfa_pkg::FUNC_ALLOC, 6'd0, 20'h12345);   // all locked: nothing available
        send_req(cfa_pkg::FUNC_UNLOCK, 6'd0, 20'h0);
        send_req(cfa_pkg::FUNC_UNLOCK, 6'd1, 20'h0);
        send_req(cfa_pkg::FUNC_UNLOCK, 6'd2, 20'h0);
        send_req(cfa_pkg::FUNC_UNLOCK, 6'd3, 20'h0);
        send_req(cfa_pkg::FUNC_TOUCH, 6'd0, 20'h0);
        send_req(cfa_pkg::FUNC_TOUCH, 6'd5, 20'h0);       // outside managed frames
        send_req(cfa_pkg::FUNC_FREE, 6'd63, 20'h0);
        send_req(cfa_pkg::FUNC_UNLOCK, 6'd63, 20'h0);
        send_req(cfa_pkg::FUNC_ALLOC, 6'd0, 20'h00001);   // frame 0 gets its second chance
        send_req(cfa_pkg::FUNC_FREE, 6'd2, 20'h0);
        send_req(cfa_pkg::FUNC_TOUCH, 6'd2, 20'h0);       // touch an empty frame
        send_req(cfa_pkg::FUNC_ALLOC, 6'd63, 20'hFFFFE);  // empty grant of the freed frame

        // shrink below the hand: sweep restarts at frame 0
        set_frames(7'd2);
        send_req(cfa_pkg::FUNC_ALLOC, 6'd63, 20'h0F0F0);
        send_req(cfa_pkg::FUNC_UNLOCK, 6'd3, 20'h0);
        send_req(cfa_pkg::FUNC_TOUCH, 6'd1, 20'h0);

        for (int p = 0; p < 10; p++) begin
            set_frames(7'(frame_plan[p]));
            steady = (p % 4 == 2);
            repeat (PHASE_ITEMS) send_random();
        end

        steady = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Allocations: %0d empty grants, %0d evictions, %0d refused",
                 empty_grants, evict_grants, refusals);
        $display("Frame counts swept from 0 to 127, with touch, unlock and free mixed in");
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/cfa_pkg.sv
rtl/cfa_ram.sv
rtl/cfa_frame_eval.sv
rtl/clock_frame_allocator_unit.sv
test/cfa_checker.sv
test/tb.sv
